FILE: src/gps_compass_frame_decoder_macros.svh
// assertion macros shared by the frame decoder rtl
// no dependencies; clocked on clk, disabled while rst_n is low
`ifndef GPS_COMPASS_FRAME_DECODER_MACROS_SVH
`define GPS_COMPASS_FRAME_DECODER_MACROS_SVH

// same-cycle implication
`define GCFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/gcfd_pkg.sv
// types, constants and decode tables for the gps/compass frame decoder
// used by gcfd_parser, gcfd_emitter and the top level

package gcfd_pkg;

  localparam logic [7:0] HDR_BYTE0 = 8'h55;
  localparam logic [7:0] HDR_BYTE1 = 8'hAA;
  localparam logic [7:0] ID_GPS    = 8'h10;
  localparam logic [7:0] ID_CMP    = 8'h20;

  localparam logic       KIND_GPS = 1'b0;
  localparam logic       KIND_CMP = 1'b1;

  localparam logic [5:0] GPS_MASK_ADDR = 6'd55;
  localparam logic [5:0] CMP_MASK_ADDR = 6'd4;
  localparam logic [4:0] GPS_LAST_IDX  = 5'd16;
  localparam logic [4:0] CMP_LAST_IDX  = 5'd2;
  localparam logic [7:0] FTYPE_2D      = 8'h02;
  localparam logic [7:0] FTYPE_3D      = 8'h03;

  typedef enum logic [2:0] {
    P_HUNT,
    P_HDR1,
    P_ID,
    P_LEN,
    P_PAY,
    P_SUMA,
    P_SUMB
  } phase_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_MASK_RD,
    E_MASK_CAP,
    E_RD,
    E_CAP,
    E_OUT
  } emit_state_t;

  typedef enum logic [2:0] {
    M_TIME,
    M_LONG,
    M_SHORT,
    M_RAW,
    M_FIX
  } item_mode_t;

  typedef struct packed {
    logic valid;
    logic kind;
  } start_t;

  // first payload byte of an item
  function automatic logic [5:0] item_addr(logic kind, logic [4:0] idx);
    logic [5:0] a;
    a = 6'd0;
    if (kind == KIND_CMP) begin
      a = {idx, 1'b0};
    end else begin
      unique case (idx)
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5: a = 6'd0;
        5'd6:    a = 6'd4;
        5'd7:    a = 6'd8;
        5'd8:    a = 6'd12;
        5'd9:    a = 6'd28;
        5'd10:   a = 6'd32;
        5'd11:   a = 6'd36;
        5'd12:   a = 6'd42;
        5'd13:   a = 6'd44;
        5'd14:   a = 6'd46;
        5'd15:   a = 6'd48;
        5'd16:   a = 6'd50;
        default: a = 6'd0;
      endcase
    end
    return a;
  endfunction

  function automatic item_mode_t item_mode(logic kind, logic [4:0] idx);
    item_mode_t m;
    m = M_SHORT;
    if (kind == KIND_GPS) begin
      unique case (idx)
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5:     m = M_TIME;
        5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11:   m = M_LONG;
        5'd12, 5'd13, 5'd14:                    m = M_SHORT;
        5'd15:                                  m = M_RAW;
        5'd16:                                  m = M_FIX;
        default:                                m = M_RAW;
      endcase
    end
    return m;
  endfunction

  // index of the last byte fetched for a mode
  function automatic logic [1:0] mode_last_byte(item_mode_t m);
    logic [1:0] n;
    unique case (m)
      M_TIME, M_LONG: n = 2'd3;
      M_SHORT:        n = 2'd1;
      M_FIX:          n = 2'd2;
      M_RAW:          n = 2'd0;
      default:        n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] time_shift(logic [4:0] idx);
    logic [4:0] s;
    unique case (idx)
      5'd0:    s = 5'd0;
      5'd1:    s = 5'd6;
      5'd2:    s = 5'd12;
      5'd3:    s = 5'd16;
      5'd4:    s = 5'd21;
      5'd5:    s = 5'd25;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [6:0] time_mask(logic [4:0] idx);
    logic [6:0] k;
    unique case (idx)
      5'd0, 5'd1: k = 7'b0111111;
      5'd2, 5'd4: k = 7'b0001111;
      5'd3:       k = 7'b0011111;
      5'd5:       k = 7'b1111111;
      default:    k = 7'b0000000;
    endcase
    return k;
  endfunction

  // xor mask for compass words, scrambled from one payload byte
  function automatic logic [7:0] compass_mask(logic [7:0] r);
    logic [7:0] m;
    m = {r[4:1], r[3:0] ^ r[7:4]} ^ {r[0], 3'b000, r[0], 3'b000};
    return m;
  endfunction

endpackage

FILE: src/gcfd_ram.sv
// generic single-write, single-read ram with registered read data
// no package dependencies

module gcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/gcfd_parser.sv
// byte-level frame parser: header hunt, running sums, payload store writes
// depends on gcfd_pkg; drives the write port of gcfd_ram

module gcfd_parser #(
  parameter int PAYLOAD_BYTES = 64,
  localparam int AW = $clog2(PAYLOAD_BYTES)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     byte_take,
  input  logic [7:0]               byte_data,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [7:0]               wr_data,
  output logic [PAYLOAD_BYTES-1:0] fill_vld,
  output gcfd_pkg::start_t         start
);

  import gcfd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic       kind_r, kind_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] sum_a_r, sum_a_nxt;
  logic [7:0] sum_b_r, sum_b_nxt;
  logic [7:0] sum_a_add, sum_b_add;
  logic [7:0] cnt_inc;
  logic [PAYLOAD_BYTES-1:0] fill_vld_r;

  assign sum_a_add = sum_a_r + byte_data;
  assign sum_b_add = sum_b_r + sum_a_add;
  assign cnt_inc   = cnt_r + 8'd1;
  assign wr_addr   = cnt_r[AW-1:0];
  assign wr_data   = byte_data;
  assign fill_vld  = fill_vld_r;

  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    sum_a_nxt   = sum_a_r;
    sum_b_nxt   = sum_b_r;
    wr_en       = 1'b0;
    start.valid = 1'b0;
    start.kind  = kind_r;
    if (byte_take) begin
      unique case (phase_r)
        P_HUNT: begin
          phase_nxt = (byte_data == HDR_BYTE0) ? P_HDR1 : P_HUNT;
        end
        P_HDR1: begin
          if (byte_data == HDR_BYTE1) begin
            sum_a_nxt = 8'd0;
            sum_b_nxt = 8'd0;
            phase_nxt = P_ID;
          end else begin
            phase_nxt = P_HUNT;
          end
        end
        P_ID: begin
          if (byte_data == ID_GPS || byte_data == ID_CMP) begin
            kind_nxt  = (byte_data == ID_CMP) ? KIND_CMP : KIND_GPS;
            sum_a_nxt = sum_a_add;
            sum_b_nxt = sum_b_add;
            phase_nxt = P_LEN;
          end else begin
            phase_nxt = P_HUNT;
          end
        end
        P_LEN: begin
          len_nxt   = byte_data;
          cnt_nxt   = 8'd0;
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          phase_nxt = P_PAY;
        end
        P_PAY: begin
          // bytes beyond the store are summed but not kept
          wr_en     = ({1'b0, cnt_r} < 9'(PAYLOAD_BYTES));
          cnt_nxt   = cnt_inc;
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          if (cnt_inc >= len_r) begin
            phase_nxt = P_SUMA;
          end
        end
        P_SUMA: begin
          phase_nxt = (byte_data == sum_a_r) ? P_SUMB : P_HUNT;
        end
        P_SUMB: begin
          phase_nxt   = P_HUNT;
          start.valid = (byte_data == sum_b_r);
        end
        default: begin
          phase_nxt = P_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= P_HUNT;
      kind_r     <= KIND_GPS;
      len_r      <= 8'd0;
      cnt_r      <= 8'd0;
      sum_a_r    <= 8'd0;
      sum_b_r    <= 8'd0;
      fill_vld_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      if (wr_en) begin
        fill_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

endmodule

FILE: src/gcfd_emitter.sv
// result sequencer: reads the payload store one byte at a time through a
// shared byte assembler and decodes one word per item; depends on gcfd_pkg

module gcfd_emitter #(
  parameter int PAYLOAD_BYTES = 64,
  localparam int AW = $clog2(PAYLOAD_BYTES)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gcfd_pkg::start_t         start,
  input  logic [PAYLOAD_BYTES-1:0] fill_vld,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  logic [7:0]               rd_data,
  output logic                     busy,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_kind,
  output logic [4:0]               out_index,
  output logic [31:0]              out_value,
  output logic                     out_last
);

  import gcfd_pkg::*;

  emit_state_t     state_r, state_nxt;
  logic            kind_r, kind_nxt;
  logic [4:0]      item_r, item_nxt;
  logic [1:0]      bsel_r, bsel_nxt;
  logic [7:0]      mask_r, mask_nxt;
  logic [3:0][7:0] acc_r, acc_nxt;
  logic            rd_vld_r;
  logic            ov_r, ov_nxt;
  logic            ok_r, ok_nxt;
  logic [4:0]      oi_r, oi_nxt;
  logic [31:0]     oval_r, oval_nxt;
  logic            ol_r, ol_nxt;

  item_mode_t  mode;
  logic [5:0]  base;
  logic [5:0]  addr6;
  logic [7:0]  rd_byte;
  logic [31:0] word;
  logic [31:0] value;
  logic [7:0]  ftype, fflags;
  logic [1:0]  fix;
  logic        last;
  logic        out_free;

  assign mode     = item_mode(kind_r, item_r);
  assign base     = item_addr(kind_r, item_r);
  assign rd_byte  = rd_vld_r ? rd_data : 8'h00;
  assign word     = acc_r ^ {4{mask_r}};
  assign ftype    = acc_r[0] ^ mask_r;
  assign fflags   = acc_r[2] ^ mask_r;
  assign last     = (kind_r == KIND_CMP) ? (item_r == CMP_LAST_IDX) : (item_r == GPS_LAST_IDX);
  assign out_free = !ov_r || out_ready;

  always_comb begin
    if (ftype == FTYPE_2D) begin
      fix = 2'd1;
    end else if (ftype == FTYPE_3D) begin
      fix = 2'd2;
    end else begin
      fix = 2'd0;
    end
    if (fix != 2'd0 && fflags[1]) begin
      fix = 2'd3;
    end
  end

  always_comb begin
    case (mode)
      M_TIME:  value = (word >> time_shift(item_r)) & {25'd0, time_mask(item_r)};
      M_LONG:  value = word;
      M_SHORT: value = {{16{word[15]}}, word[15:0]};
      M_RAW:   value = {24'd0, acc_r[0]};
      M_FIX:   value = {30'd0, fix};
      default: value = 32'd0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    item_nxt  = item_r;
    bsel_nxt  = bsel_r;
    mask_nxt  = mask_r;
    acc_nxt   = acc_r;
    ok_nxt    = ok_r;
    oi_nxt    = oi_r;
    oval_nxt  = oval_r;
    ol_nxt    = ol_r;
    ov_nxt    = ov_r && !out_ready;
    rd_en     = 1'b0;
    addr6     = base + {4'd0, bsel_r};
    unique case (state_r)
      E_IDLE: begin
        if (start.valid) begin
          kind_nxt  = start.kind;
          item_nxt  = 5'd0;
          state_nxt = E_MASK_RD;
        end
      end
      E_MASK_RD: begin
        rd_en     = 1'b1;
        addr6     = (kind_r == KIND_CMP) ? CMP_MASK_ADDR : GPS_MASK_ADDR;
        state_nxt = E_MASK_CAP;
      end
      E_MASK_CAP: begin
        mask_nxt  = (kind_r == KIND_CMP) ? compass_mask(rd_byte) : rd_byte;
        bsel_nxt  = 2'd0;
        state_nxt = E_RD;
      end
      E_RD: begin
        rd_en     = 1'b1;
        state_nxt = E_CAP;
      end
      E_CAP: begin
        acc_nxt[bsel_r] = rd_byte;
        if (bsel_r == mode_last_byte(mode)) begin
          state_nxt = E_OUT;
        end else begin
          bsel_nxt  = bsel_r + 2'd1;
          state_nxt = E_RD;
        end
      end
      E_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ok_nxt    = kind_r;
          oi_nxt    = item_r;
          oval_nxt  = value;
          ol_nxt    = last;
          item_nxt  = item_r + 5'd1;
          bsel_nxt  = 2'd0;
          state_nxt = last ? E_IDLE : E_RD;
        end
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  assign rd_addr = AW'(addr6);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    item_r <= item_nxt;
    bsel_r <= bsel_nxt;
    mask_r <= mask_nxt;
    acc_r  <= acc_nxt;
    ok_r   <= ok_nxt;
    oi_r   <= oi_nxt;
    oval_r <= oval_nxt;
    ol_r   <= ol_nxt;
    // entries never written since reset read as zero
    if (rd_en) begin
      rd_vld_r <= fill_vld[rd_addr];
    end
  end

  assign busy      = (state_r != E_IDLE);
  assign out_valid = ov_r;
  assign out_kind  = ok_r;
  assign out_index = oi_r;
  assign out_value = oval_r;
  assign out_last  = ol_r;

endmodule

FILE: src/gps_compass_frame_decoder.sv
// channel  | signals                         | role
// in_      | tvalid tready tdata[7:0]        | received bytes
// out_     | tvalid tready tdata tuser tlast | decoded frame words
//
// one byte is taken per cycle while no frame is being decoded
// after a good frame in_tready drops; words come from the single payload
// store read port: a mask byte, then E_RD and E_CAP per byte read and E_OUT
// per word, which waits on a full output register while out_tready is low
// reset clears phase, sums and the store's valid bits
// top level; depends on gcfd_pkg, gcfd_ram, gcfd_parser, gcfd_emitter

`include "gps_compass_frame_decoder_macros.svh"

module gps_compass_frame_decoder #(
  parameter int PAYLOAD_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] item_index, [36:5] item_value, rest zero
  output logic        out_tuser,  // frame_kind
  output logic        out_tlast   // last_item
);

  import gcfd_pkg::*;

  localparam int AW = $clog2(PAYLOAD_BYTES);

  logic                     take;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [7:0]               wr_data;
  logic [PAYLOAD_BYTES-1:0] fill_vld;
  start_t                   start;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic [7:0]               rd_data;
  logic                     busy;
  logic [4:0]               out_index;
  logic [31:0]              out_value;

  assign in_tready = !busy;
  assign take      = in_tvalid && in_tready;

  gcfd_parser #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (take),
    .byte_data (in_tdata),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .fill_vld  (fill_vld),
    .start     (start)
  );

  gcfd_ram #(.WIDTH(8), .DEPTH(PAYLOAD_BYTES)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gcfd_emitter #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .fill_vld  (fill_vld),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (busy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_index (out_index),
    .out_value (out_value),
    .out_last  (out_tlast)
  );

  assign out_tdata = {3'b000, out_value, out_index};

  // a checked frame stops byte intake on the next cycle
  `GCFD_ASSERT_NEXT(a_start_blocks_input, start.valid, !in_tready, "input open after frame end")

  // the final word carries the last index of its frame kind
  `GCFD_ASSERT_NOW(a_last_index, out_tvalid && out_tlast, (out_tuser == KIND_CMP) ? (out_index == CMP_LAST_IDX) : (out_index == GPS_LAST_IDX), "tlast on wrong index")

  // no payload writes while words are being read back
  `GCFD_ASSERT_NOW(a_no_write_busy, busy, !wr_en && !start.valid, "store written during readout")

endmodule
